FILE: hw/rtl/kmp_pkg.sv
// Shared constants for the streaming KMP substring search block.
// Used by the channel interfaces, the top level and the checker; depends on nothing else.
package kmp_pkg;

    localparam int PAT_MAX = 64;
    localparam int ADDR_W  = $clog2(PAT_MAX);
    localparam int LEN_W   = $clog2(PAT_MAX + 1);
    localparam int POS_W   = 32;
    localparam int BYTE_W  = 8;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

endpackage

FILE: hw/rtl/kmp_if.sv
// Valid/ready channel interfaces for the KMP search block.
// Depends on kmp_pkg for the byte and position widths.
interface kmp_byte_if;
    import kmp_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] data;
    logic              last;

    modport source (output valid, output op, output data, output last, input ready);
    modport sink   (input valid, input op, input data, input last, output ready);
endinterface

interface kmp_result_if;
    import kmp_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic             truncated;

    modport source (output valid, output found, output position, output truncated,
                    input ready);
    modport sink   (input valid, input found, input position, input truncated,
                    output ready);
endinterface

FILE: hw/rtl/kmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the pattern bytes and the failure table.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/kmp_substring_search.sv
// Top level of the streaming Knuth-Morris-Pratt substring search.
// Depends on kmp_pkg, the channel interfaces in kmp_if and kmp_ram.
//
// Usage: items arrive on byte_ch. An item with op = 0 is a pattern byte; the
// pattern ends with last = 1. The failure table entry for each pattern byte is
// built as the byte arrives. Items with op = 1 are text bytes, and the text
// ends with last = 1. The first occurrence of the pattern in the text gives
// one result item on result_ch with found = 1 and its zero-based start offset.
// Text after a match is ignored until the last text byte. If the text ends
// without a match, the last text byte gives found = 0 and position 0. The
// truncated bit tells that the pattern was longer than PAT_MAX bytes and cut.
//
// Flow: a pattern byte that is the first byte or is dropped is handled in
// S_IDLE alone. Any other pattern byte, and a searched text byte, goes
// through S_CMP, and each KMP fallback adds a pass through S_FALL and back.
// A searched text byte that produces a result then goes through S_EMIT. A
// text byte after a match or with an empty pattern is handled in S_IDLE
// alone, or goes to S_EMIT when it is the last byte and reports not found.
// Each fallback is a round trip through the registered reads of the failure
// table RAM and the pattern RAM. Fallbacks never outnumber advances.
// byte_ch.ready is low while a byte is in work. Results sit in an output
// register, so new bytes are taken while a result waits; only a byte that
// produces a second result waits until the first one is taken. Reset clears
// all control state; the RAMs hold no meaning until a pattern is loaded.
module kmp_substring_search
    import kmp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    kmp_byte_if.sink            byte_ch,
    kmp_result_if.source        result_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_FALL = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] prefix_reg, prefix_next;
    logic [LEN_W-1:0] match_reg, match_next;
    logic [LEN_W-1:0] ptr_reg, ptr_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic             reported_reg, reported_next;
    logic             overflow_reg, overflow_next;
    logic             loading_reg, loading_next;

    // Byte under work.
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              op_reg, op_next;
    logic              last_reg, last_next;

    // Pending result and output register.
    logic             res_found_reg, res_found_next;
    logic [POS_W-1:0] res_pos_reg, res_pos_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic             out_trunc_reg, out_trunc_next;

    // RAM ports.
    logic              pat_wr_en;
    logic [ADDR_W-1:0] pat_wr_addr;
    logic [ADDR_W-1:0] pat_rd_addr;
    logic [BYTE_W-1:0] pat_rd_data;
    logic              fail_wr_en;
    logic [ADDR_W-1:0] fail_wr_addr;
    logic [LEN_W-1:0]  fail_wr_data;
    logic [ADDR_W-1:0] fail_rd_addr;
    logic [LEN_W-1:0]  fail_rd_data;

    logic             accept;
    logic             slot_free;
    logic [LEN_W-1:0] new_k;
    logic [LEN_W-1:0] load_idx;

    kmp_ram #(.WIDTH(BYTE_W), .DEPTH(PAT_MAX)) u_pat_ram (
        .clk     (clk),
        .wr_en   (pat_wr_en),
        .wr_addr (pat_wr_addr),
        .wr_data (byte_ch.data),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    kmp_ram #(.WIDTH(LEN_W), .DEPTH(PAT_MAX)) u_fail_ram (
        .clk     (clk),
        .wr_en   (fail_wr_en),
        .wr_addr (fail_wr_addr),
        .wr_data (fail_wr_data),
        .rd_addr (fail_rd_addr),
        .rd_data (fail_rd_data)
    );

    assign byte_ch.ready      = (state_reg == S_IDLE);
    assign accept             = byte_ch.valid && byte_ch.ready;
    assign slot_free          = !out_valid_reg || result_ch.ready;
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.found    = out_found_reg;
    assign result_ch.position = out_pos_reg;
    assign result_ch.truncated = out_trunc_reg;

    // A pattern byte that opens a new pattern lands at index zero.
    assign load_idx = loading_reg ? len_reg : '0;
    // The shared compare step: advance the pointer on a byte match.
    assign new_k    = (pat_rd_data == byte_reg) ? ptr_reg + LEN_W'(1) : ptr_reg;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        prefix_next    = prefix_reg;
        match_next     = match_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        reported_next  = reported_reg;
        overflow_next  = overflow_reg;
        loading_next   = loading_reg;
        byte_next      = byte_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_trunc_next = out_trunc_reg;

        pat_wr_en    = 1'b0;
        pat_wr_addr  = load_idx[ADDR_W-1:0];
        pat_rd_addr  = ptr_reg[ADDR_W-1:0];
        fail_wr_en   = 1'b0;
        fail_wr_addr = idx_reg[ADDR_W-1:0];
        fail_wr_data = new_k;
        fail_rd_addr = ptr_reg[ADDR_W-1:0] - ADDR_W'(1);

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next = byte_ch.data;
                    op_next   = byte_ch.op;
                    last_next = byte_ch.last;
                    if (byte_ch.op == OP_PATTERN)
                    begin
                        if (!loading_reg)
                        begin
                            overflow_next = 1'b0;
                            match_next    = '0;
                            count_next    = '0;
                            reported_next = 1'b0;
                        end
                        loading_next = !byte_ch.last;
                        if (load_idx == LEN_W'(PAT_MAX))
                        begin
                            overflow_next = 1'b1;
                        end
                        else if (load_idx == '0)
                        begin
                            pat_wr_en    = 1'b1;
                            fail_wr_en   = 1'b1;
                            fail_wr_addr = '0;
                            fail_wr_data = '0;
                            prefix_next  = '0;
                            len_next     = LEN_W'(1);
                        end
                        else
                        begin
                            pat_wr_en   = 1'b1;
                            idx_next    = load_idx;
                            ptr_next    = prefix_reg;
                            pat_rd_addr = prefix_reg[ADDR_W-1:0];
                            state_next  = S_CMP;
                        end
                    end
                    else
                    begin
                        loading_next = 1'b0;
                        if (!reported_reg && len_reg != '0)
                        begin
                            ptr_next    = match_reg;
                            pat_rd_addr = match_reg[ADDR_W-1:0];
                            state_next  = S_CMP;
                        end
                        else if (byte_ch.last)
                        begin
                            // Text ends with no search running.
                            if (!reported_reg)
                            begin
                                res_found_next = 1'b0;
                                res_pos_next   = '0;
                                state_next     = S_EMIT;
                            end
                            match_next    = '0;
                            count_next    = '0;
                            reported_next = 1'b0;
                        end
                    end
                end
            end

            S_CMP:
            begin
                if (ptr_reg != '0 && pat_rd_data != byte_reg)
                begin
                    state_next = S_FALL;
                end
                else if (op_reg == OP_PATTERN)
                begin
                    fail_wr_en  = 1'b1;
                    prefix_next = new_k;
                    len_next    = idx_reg + LEN_W'(1);
                    state_next  = S_IDLE;
                end
                else
                begin
                    match_next = new_k;
                    state_next = S_IDLE;
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + POS_W'(1);
                    end
                    if (new_k >= len_reg)
                    begin
                        reported_next  = 1'b1;
                        match_next     = '0;
                        res_found_next = 1'b1;
                        res_pos_next   = count_reg - POS_W'(len_reg) + POS_W'(1);
                        state_next     = S_EMIT;
                    end
                    else if (last_reg)
                    begin
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = S_EMIT;
                    end
                    if (last_reg)
                    begin
                        match_next    = '0;
                        count_next    = '0;
                        reported_next = 1'b0;
                    end
                end
            end

            S_FALL:
            begin
                ptr_next    = fail_rd_data;
                pat_rd_addr = fail_rd_data[ADDR_W-1:0];
                state_next  = S_CMP;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_pos_next   = res_pos_reg;
                    out_trunc_next = overflow_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            prefix_reg    <= '0;
            match_reg     <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            loading_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            prefix_reg    <= prefix_next;
            match_reg     <= match_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            overflow_reg  <= overflow_next;
            loading_reg   <= loading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        op_reg        <= op_next;
        last_reg      <= last_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_trunc_reg <= out_trunc_next;
    end

endmodule

FILE: hw/rtl/kmp_checker.sv
// Port-level assertions for kmp_substring_search, attached by a bind.
// Depends on kmp_pkg and on the top level's channel ports.
module kmp_checker
    import kmp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             byte_valid,
    input logic             byte_ready,
    input logic             byte_op,
    input logic             res_valid,
    input logic             res_ready,
    input logic             res_found,
    input logic [POS_W-1:0] res_position
);

    // A waiting result item stays valid and keeps its position until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_position))
        else $error("result item changed while stalled");

    // A not-found result always carries position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_position == '0)
        else $error("not-found result with nonzero position");

    // A pattern byte never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_op == OP_PATTERN |=> !$rose(res_valid))
        else $error("result appeared after a pattern byte");

    // A new result is only loaded while the input side is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(byte_ready))
        else $error("result appeared without a byte in work");

endmodule

bind kmp_substring_search kmp_checker u_kmp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_ch.valid),
    .byte_ready   (byte_ch.ready),
    .byte_op      (byte_ch.op),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .res_found    (result_ch.found),
    .res_position (result_ch.position)
);
